[rtl/core/size_latency_histogram_assert.svh]
// Assertion macros used by the histogram checker.
`ifndef SIZE_LATENCY_HISTOGRAM_ASSERT_SVH
`define SIZE_LATENCY_HISTOGRAM_ASSERT_SVH

// Same-cycle implication, sampled on clk, idle in reset.
`define SLH_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, idle in reset.
`define SLH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/slh_pkg.sv]
// Types and constants shared by the size/latency histogram modules.
package slh_pkg;

	localparam int MAX_BINS    = 4;
	localparam int BIN_W       = 2;
	localparam int SIZE_W      = 40;
	localparam int TIME_W      = 32;
	localparam int MSEC_W      = 10;
	localparam int COUNT_W     = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 40;
	localparam int MS_PER_SEC  = 1000;
	// elapsed milliseconds, signed, wide enough for any second difference
	localparam int MS_W        = 44;

	// request codes
	localparam logic [1:0] REQ_RECORD = 2'd0;
	localparam logic [1:0] REQ_CLEAR  = 2'd1;
	localparam logic [1:0] REQ_READ   = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LIMIT_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_LIMIT_0 = 3'd4;

	// work handed from the classifier to the counter bank
	typedef enum logic [2:0] {
		OP_EMPTY,   // answer all zero
		OP_COUNT,   // increment the selected counter
		OP_CLEAR,   // zero every counter
		OP_READ,    // return the selected counter
		OP_ECHO     // return the bins with a zero value
	} slh_op_t;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [SIZE_W-1:0] bytes_sent;
		logic [TIME_W-1:0] launch_sec;
		logic [MSEC_W-1:0] launch_msec;
		logic [TIME_W-1:0] now_sec;
		logic [MSEC_W-1:0] now_msec;
		logic [BIN_W-1:0]  read_size_bin;
		logic [BIN_W-1:0]  read_time_bin;
	} slh_in_t;

	typedef struct packed {
		logic               counted;
		logic [BIN_W-1:0]   size_bin;
		logic [BIN_W-1:0]   time_bin;
		logic [COUNT_W-1:0] count_value;
	} slh_out_t;

	typedef struct packed {
		slh_op_t          op;
		logic [BIN_W-1:0] size_bin;
		logic [BIN_W-1:0] time_bin;
	} slh_entry_t;

	// queue status seen by the two sides
	typedef struct packed {
		logic empty;
		logic full;
	} slh_qstat_t;

endpackage

[rtl/core/slh_front.sv]
// Classifier: holds the bin limits, computes elapsed time and picks the bin.
module slh_front #(
	parameter int SIZE_BINS = 4,
	parameter int TIME_BINS = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  slh_pkg::slh_in_t                  in_data,
	input  logic                              cfg_we,
	input  logic [slh_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [slh_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  slh_pkg::slh_qstat_t               qstat,
	output logic                              push,
	output slh_pkg::slh_entry_t               push_entry
);
	import slh_pkg::*;

	logic [SIZE_W-1:0] size_limit_q [MAX_BINS];
	logic [TIME_W-1:0] time_limit_q [MAX_BINS];

	logic                     v_s1;
	logic [1:0]               req_s1;
	logic signed [MS_W-1:0]   prod_s1;
	logic signed [MSEC_W:0]   dm_s1;
	logic [MAX_BINS-1:0]      size_hit_s1;
	logic [BIN_W-1:0]         rsb_s1;
	logic [BIN_W-1:0]         rtb_s1;
	logic                     rd_ok_s1;

	logic                     v_s2;
	slh_entry_t               entry_s2;

	logic                     adv;
	logic signed [TIME_W:0]   ds;
	logic signed [MS_W-1:0]   ds_x;
	logic [MAX_BINS-1:0]      size_hit;
	logic signed [MS_W-1:0]   ms;
	logic [MAX_BINS-1:0]      time_hit;
	logic                     s_found;
	logic [BIN_W-1:0]         s_sel;
	logic                     t_found;
	logic [BIN_W-1:0]         t_sel;
	slh_entry_t               entry_d;

	// hold every stage while the queue cannot take the last one
	assign in_stall = v_s2 && qstat.full;
	assign adv      = !in_stall;
	assign push     = v_s2 && !qstat.full;
	assign push_entry = entry_s2;

	// write bin limits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_BINS; i++) begin
				size_limit_q[i] <= '1;
				time_limit_q[i] <= '1;
			end
		end else if (cfg_we) begin
			if (cfg_index < CFG_TIME_LIMIT_0) begin
				size_limit_q[cfg_index[BIN_W-1:0]] <= cfg_data[SIZE_W-1:0];
			end else begin
				time_limit_q[cfg_index[BIN_W-1:0]] <= cfg_data[TIME_W-1:0];
			end
		end
	end

	// second difference and size compares
	always_comb begin
		ds   = $signed({1'b0, in_data.now_sec}) - $signed({1'b0, in_data.launch_sec});
		ds_x = MS_W'(ds);
		for (int i = 0; i < MAX_BINS; i++) begin
			size_hit[i] = (i < SIZE_BINS) && (in_data.bytes_sent <= size_limit_q[i]);
		end
	end

	// stage 1: scale seconds to milliseconds, register the size compares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			req_s1      <= in_data.req_type;
			prod_s1     <= ds_x * $signed(MS_W'(MS_PER_SEC));
			dm_s1       <= $signed({1'b0, in_data.now_msec}) -
				$signed({1'b0, in_data.launch_msec});
			size_hit_s1 <= size_hit;
			rsb_s1      <= in_data.read_size_bin;
			rtb_s1      <= in_data.read_time_bin;
			rd_ok_s1    <= ({1'b0, in_data.read_size_bin} < (BIN_W+1)'(SIZE_BINS)) &&
				({1'b0, in_data.read_time_bin} < (BIN_W+1)'(TIME_BINS));
		end
	end

	// elapsed time, time compares and first-match pick
	always_comb begin
		ms = prod_s1 + MS_W'(dm_s1);
		for (int i = 0; i < MAX_BINS; i++) begin
			time_hit[i] = (i < TIME_BINS) && (ms <= $signed({12'b0, time_limit_q[i]}));
		end
		s_found = 1'b0;
		s_sel   = '0;
		for (int i = MAX_BINS - 1; i >= 0; i--) begin
			if (size_hit_s1[i]) begin
				s_found = 1'b1;
				s_sel   = BIN_W'(i);
			end
		end
		t_found = 1'b0;
		t_sel   = '0;
		for (int i = MAX_BINS - 1; i >= 0; i--) begin
			if (time_hit[i]) begin
				t_found = 1'b1;
				t_sel   = BIN_W'(i);
			end
		end
	end

	// build the queue entry
	always_comb begin
		entry_d.op       = OP_EMPTY;
		entry_d.size_bin = '0;
		entry_d.time_bin = '0;
		case (req_s1)
			REQ_RECORD: begin
				if (s_found && t_found) begin
					entry_d.op       = OP_COUNT;
					entry_d.size_bin = s_sel;
					entry_d.time_bin = t_sel;
				end
			end
			REQ_CLEAR: begin
				entry_d.op = OP_CLEAR;
			end
			REQ_READ: begin
				entry_d.op       = rd_ok_s1 ? OP_READ : OP_ECHO;
				entry_d.size_bin = rsb_s1;
				entry_d.time_bin = rtb_s1;
			end
			default: begin
				entry_d.op = OP_EMPTY;
			end
		endcase
	end

	// stage 2: classified request waiting for the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			entry_s2 <= entry_d;
		end
	end

endmodule

[rtl/core/slh_queue.sv]
// Short queue of classified requests between classifier and counter bank.
module slh_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  slh_pkg::slh_entry_t  push_entry,
	input  logic                 pop,
	output slh_pkg::slh_entry_t  head,
	output slh_pkg::slh_qstat_t  qstat
);
	import slh_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	slh_entry_t         mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     count_q;

	assign qstat.empty = (count_q == '0);
	assign qstat.full  = (count_q == (PTR_W+1)'(DEPTH));
	assign head        = mem_q[rd_ptr_q];

	// store pushed requests
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/slh_back.sv]
// Counter bank: applies one queued request per cycle while its output is not stalled, and registers the result.
module slh_back #(
	parameter int SIZE_BINS = 4,
	parameter int TIME_BINS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  slh_pkg::slh_entry_t  head,
	input  slh_pkg::slh_qstat_t  qstat,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output slh_pkg::slh_out_t    out_data
);
	import slh_pkg::*;

	localparam int CNT_DEPTH = SIZE_BINS * TIME_BINS;
	localparam int IDX_W     = (CNT_DEPTH > 1) ? $clog2(CNT_DEPTH) : 1;

	logic [COUNT_W-1:0] cnt_q [CNT_DEPTH];
	logic               out_valid_q;
	slh_out_t           out_data_q;

	logic [IDX_W-1:0]   idx;
	logic [COUNT_W-1:0] cur;
	logic [COUNT_W-1:0] inc;
	slh_out_t           res;

	assign pop       = !qstat.empty && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// select the counter and form the result
	always_comb begin
		idx = IDX_W'(int'(head.size_bin) * TIME_BINS + int'(head.time_bin));
		cur = cnt_q[idx];
		inc = cur + 1'b1;
		res = '0;
		case (head.op)
			OP_COUNT: begin
				res.counted     = 1'b1;
				res.size_bin    = head.size_bin;
				res.time_bin    = head.time_bin;
				res.count_value = inc;
			end
			OP_READ: begin
				res.size_bin    = head.size_bin;
				res.time_bin    = head.time_bin;
				res.count_value = cur;
			end
			OP_ECHO: begin
				res.size_bin = head.size_bin;
				res.time_bin = head.time_bin;
			end
			default: begin
				res = '0;
			end
		endcase
	end

	// update counters: increment one or clear all
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CNT_DEPTH; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (pop) begin
			if (head.op == OP_CLEAR) begin
				for (int i = 0; i < CNT_DEPTH; i++) begin
					cnt_q[i] <= '0;
				end
			end else if (head.op == OP_COUNT) begin
				cnt_q[idx] <= inc;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_data_q <= res;
		end
	end

endmodule

[rtl/core/size_latency_histogram.sv]
// Size/latency histogram: a grid of SIZE_BINS x TIME_BINS wrapping 32-bit
// counters, indexed by transfer size and elapsed milliseconds. Every request
// (record, clear, read) returns exactly one result. Throughput is one request
// per clock while neither side stalls; a taken request is registered in the
// two classifier stages (the seconds-to-milliseconds scaling stage, then the
// bin compare stage), the four-entry request queue and the output register, in
// that order. The counter bank applies one request per cycle while its output
// is not stalled; a clear zeroes the whole grid at once. Counters and limits
// come out of reset ready, with no clearing pass. The user must write bin
// limits through the cfg port (indexes 0-3 size limits, 4-7 time limits) only
// while no request is pending; the block itself does not enforce this.
module size_latency_histogram #(
	parameter int SIZE_BINS = 4,
	parameter int TIME_BINS = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  slh_pkg::slh_in_t                in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output slh_pkg::slh_out_t               out_data,
	input  logic                            cfg_we,
	input  logic [slh_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [slh_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import slh_pkg::*;

	logic       push;
	logic       pop;
	slh_entry_t push_entry;
	slh_entry_t head;
	slh_qstat_t qstat;

	// classify requests
	slh_front #(
		.SIZE_BINS(SIZE_BINS),
		.TIME_BINS(TIME_BINS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.qstat      (qstat),
		.push       (push),
		.push_entry (push_entry)
	);

	// decouple the two sides
	slh_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	// count and answer
	slh_back #(
		.SIZE_BINS(SIZE_BINS),
		.TIME_BINS(TIME_BINS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

[rtl/core/slh_checker.sv]
// Port-level checks for the size/latency histogram, bound to the top level.
`include "size_latency_histogram_assert.svh"

module slh_checker #(
	parameter int SIZE_BINS = 4,
	parameter int TIME_BINS = 4
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_stall,
	input logic                            out_valid,
	input logic                            out_stall,
	input slh_pkg::slh_out_t               out_data
);
	import slh_pkg::*;

	logic size_ok;
	logic time_ok;

	assign size_ok   = {1'b0, out_data.size_bin} < (BIN_W+1)'(SIZE_BINS);
	assign time_ok   = {1'b0, out_data.time_bin} < (BIN_W+1)'(TIME_BINS);

	// a held result keeps its value
	`SLH_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

	// a counted result always names a counter inside the grid
	`SLH_ASSERT_NOW(a_counted_in_grid, out_valid && out_data.counted, size_ok && time_ok, "counted bin outside grid")

	// a nonzero value without counting comes only from a read inside the grid
	`SLH_ASSERT_NOW(a_read_in_grid, out_valid && !out_data.counted && (out_data.count_value != '0), size_ok && time_ok, "read value from bin outside grid")

	// the input backs up only behind a waiting result
	`SLH_ASSERT_NOW(a_stall_behind_result, in_stall, out_valid, "input stalled with no result waiting")

endmodule

bind size_latency_histogram slh_checker #(
	.SIZE_BINS(SIZE_BINS),
	.TIME_BINS(TIME_BINS)
) u_slh_checker (.*);

[test/tb_size_latency_histogram.sv]
// Self-checking testbench for the size/latency histogram: binning, clear, read and handshakes.
module tb_size_latency_histogram;
	timeunit 1ns;
	timeprecision 1ps;
	import slh_pkg::*;

	localparam int SIZE_BINS      = 4;
	localparam int TIME_BINS      = 4;
	localparam int PIPE_LATENCY   = 4;
	localparam int MAX_GAP        = 12;
	localparam int LONG_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SHOW_ERRORS    = 40;
	localparam int PHASE_ITEMS    = 340;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic [SIZE_W-1:0] SIZE_MAX = '1;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	typedef logic [SIZE_W-1:0] size_set_t [MAX_BINS];
	typedef logic [TIME_W-1:0] time_set_t [MAX_BINS];

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	slh_in_t               in_data;
	logic                  out_valid;
	logic                  out_stall;
	slh_out_t              out_data;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// mirror of the limits and the counter grid
	size_set_t          size_lim;
	time_set_t          time_lim;
	logic [COUNT_W-1:0] grid_count [MAX_BINS*MAX_BINS];
	slh_out_t           pending_bins [$];

	int          fail_count    = 0;
	int          sent_count    = 0;
	int          counted_count = 0;
	int          settings_used = 0;
	int          idle_cycles   = 0;
	int unsigned long_hold_req = 0;
	bit          sender_quiet  = 1'b0;

	always begin
		#4ns clk = 1'b1;
		#4ns clk = 1'b0;
	end

	size_latency_histogram #(
		.SIZE_BINS(SIZE_BINS),
		.TIME_BINS(TIME_BINS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Apply one request to the mirror and return the result it should produce.
	function automatic slh_out_t predict_request(slh_in_t r);
		slh_out_t res;
		longint   elapsed;
		int       s;
		int       t;
		res = '0;
		case (r.req_type)
			REQ_RECORD: begin
				elapsed = (longint'(r.now_sec) - longint'(r.launch_sec)) * MS_PER_SEC
					+ longint'(r.now_msec) - longint'(r.launch_msec);
				if (elapsed < 0)
					elapsed = 0;
				s = 0;
				while (s < SIZE_BINS && r.bytes_sent > size_lim[s])
					s++;
				// only the first matching size bin is searched for a time bin
				t = 0;
				if (s < SIZE_BINS) begin
					while (t < TIME_BINS && elapsed > longint'(time_lim[t]))
						t++;
				end
				if (s < SIZE_BINS && t < TIME_BINS) begin
					grid_count[s*MAX_BINS+t] = grid_count[s*MAX_BINS+t] + 1'b1;
					res.counted     = 1'b1;
					res.size_bin    = BIN_W'(s);
					res.time_bin    = BIN_W'(t);
					res.count_value = grid_count[s*MAX_BINS+t];
				end
			end
			REQ_CLEAR: begin
				foreach (grid_count[i])
					grid_count[i] = '0;
			end
			REQ_READ: begin
				res.size_bin = r.read_size_bin;
				res.time_bin = r.read_time_bin;
				if (int'(r.read_size_bin) < SIZE_BINS && int'(r.read_time_bin) < TIME_BINS)
					res.count_value =
						grid_count[int'(r.read_size_bin)*MAX_BINS+int'(r.read_time_bin)];
			end
			default: ;
		endcase
		return res;
	endfunction

	// Offer one request after a random gap; hold it until taken, then log its result.
	task automatic send_request(slh_in_t r);
		int gap;
		gap = sender_quiet ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= r;
		do
			@(posedge clk);
		while (in_stall);
		pending_bins.push_back(predict_request(r));
		sent_count++;
	endtask

	// Drop valid and wait until every result is back and the pipe is empty.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_bins.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	// Write all eight bin limits while the block is idle.
	task automatic program_limits(size_set_t sz, time_set_t tm);
		int i;
		wait_idle();
		for (i = 0; i < MAX_BINS; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= CFG_SIZE_LIMIT_0 + CFG_IDX_W'(i);
			cfg_data  <= sz[i];
			@(posedge clk);
			size_lim[i] = sz[i];
		end
		// upper data bits are junk for the 32-bit time limits
		for (i = 0; i < MAX_BINS; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= CFG_TIME_LIMIT_0 + CFG_IDX_W'(i);
			cfg_data  <= {8'($urandom), tm[i]};
			@(posedge clk);
			time_lim[i] = tm[i];
		end
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	function automatic logic [SIZE_W-1:0] random_bytes();
		return {8'($urandom), 32'($urandom)};
	endfunction

	function automatic slh_in_t random_fields();
		slh_in_t r;
		r.req_type      = 2'($urandom);
		r.bytes_sent    = random_bytes();
		r.launch_sec    = $urandom;
		r.launch_msec   = 10'($urandom);
		r.now_sec       = $urandom;
		r.now_msec      = 10'($urandom);
		r.read_size_bin = 2'($urandom);
		r.read_time_bin = 2'($urandom);
		return r;
	endfunction

	function automatic slh_in_t record_at(logic [SIZE_W-1:0] bytes, logic [TIME_W-1:0] ss,
			logic [MSEC_W-1:0] sm, logic [TIME_W-1:0] ns, logic [MSEC_W-1:0] nm);
		slh_in_t r;
		r             = '0;
		r.req_type    = REQ_RECORD;
		r.bytes_sent  = bytes;
		r.launch_sec  = ss;
		r.launch_msec = sm;
		r.now_sec     = ns;
		r.now_msec    = nm;
		return r;
	endfunction

	function automatic slh_in_t simple_req(logic [1:0] code, logic [BIN_W-1:0] rs,
			logic [BIN_W-1:0] rt);
		slh_in_t r;
		r               = '0;
		r.req_type      = code;
		r.read_size_bin = rs;
		r.read_time_bin = rt;
		return r;
	endfunction

	// Byte count on, just below or just above a size limit, or somewhere under it.
	function automatic logic [SIZE_W-1:0] bytes_near_limit();
		longint base;
		longint v;
		base = longint'(size_lim[$urandom_range(0, SIZE_BINS-1)]);
		case ($urandom_range(0, 3))
			0: v = base - 1;
			1: v = base;
			2: v = base + 1;
			default: v = longint'(random_bytes()) % (base + 1);
		endcase
		if (v < 0)
			v = 0;
		if (v > longint'(SIZE_MAX))
			v = longint'(SIZE_MAX);
		return SIZE_W'(v);
	endfunction

	// Elapsed time around a time limit, under it, or negative.
	function automatic longint elapsed_near_limit();
		longint base;
		longint v;
		base = longint'(time_lim[$urandom_range(0, TIME_BINS-1)]);
		case ($urandom_range(0, 5))
			0: v = base - 1;
			1: v = base;
			2: v = base + 1;
			3: v = -longint'($urandom_range(1, 5000));
			default: v = longint'($urandom) % (base + 1);
		endcase
		return v;
	endfunction

	// Record with a chosen elapsed time spread over random start and finish stamps.
	function automatic slh_in_t timed_record(logic [SIZE_W-1:0] bytes, longint elapsed);
		slh_in_t r;
		longint  start_ms;
		longint  end_ms;
		r             = random_fields();
		r.req_type    = REQ_RECORD;
		r.bytes_sent  = bytes;
		r.launch_sec  = TIME_W'($urandom_range(10, 32'h7FFF_FFFF));
		r.launch_msec = MSEC_W'($urandom_range(0, 999));
		start_ms      = longint'(r.launch_sec) * MS_PER_SEC + longint'(r.launch_msec);
		end_ms        = start_ms + elapsed;
		r.now_sec     = TIME_W'(end_ms / MS_PER_SEC);
		r.now_msec    = MSEC_W'(end_ms % MS_PER_SEC);
		// same instant, spelled with an overlong millisecond field
		if (r.now_sec != 0 && r.now_msec < 24 && $urandom_range(0, 3) == 0) begin
			r.now_sec  = r.now_sec - 1'b1;
			r.now_msec = r.now_msec + 10'd1000;
		end
		return r;
	endfunction

	// Mostly well-formed records near the limits, the rest raw noise and other codes.
	function automatic slh_in_t random_request();
		slh_in_t     r;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 68) begin
			r = timed_record(bytes_near_limit(), elapsed_near_limit());
		end else begin
			r = random_fields();
			if (pick < 78)
				r.req_type = REQ_RECORD;
			else if (pick < 94)
				r.req_type = REQ_READ;
			else if (pick < 97)
				r.req_type = REQ_CLEAR;
			else
				r.req_type = REQ_UNUSED;
		end
		return r;
	endfunction

	task automatic report_mismatch(string field, longint unsigned want, longint unsigned got);
		fail_count++;
		if (fail_count <= SHOW_ERRORS)
			$error("%s: expected %0d, got %0d", field, want, got);
	endtask

	// Compare each taken result with the oldest prediction.
	always @(posedge clk) begin : result_check
		slh_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_bins.size() == 0) begin
				fail_count++;
				$error("result with nothing pending: counted=%0d size_bin=%0d time_bin=%0d count=%0d",
					out_data.counted, out_data.size_bin, out_data.time_bin,
					out_data.count_value);
			end else begin
				want = pending_bins.pop_front();
				if (out_data.counted !== want.counted)
					report_mismatch("counted", want.counted, out_data.counted);
				if (out_data.size_bin !== want.size_bin)
					report_mismatch("size_bin", want.size_bin, out_data.size_bin);
				if (out_data.time_bin !== want.time_bin)
					report_mismatch("time_bin", want.time_bin, out_data.time_bin);
				if (out_data.count_value !== want.count_value)
					report_mismatch("count_value", want.count_value, out_data.count_value);
			end
			if (out_data.counted === 1'b1)
				counted_count++;
		end
	end

	// Stall the output a random number of cycles per result, with quiet stretches
	// and an occasional long hold.
	initial begin : result_sink
		int unsigned stall_left;
		int unsigned hold_left;
		int unsigned taken;
		bit          quiet;
		stall_left = 0;
		hold_left  = 0;
		taken      = 0;
		quiet      = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req != 0) begin
				hold_left     = long_hold_req;
				long_hold_req = 0;
			end
			if (out_valid && !out_stall) begin
				taken++;
				if (taken % 64 == 0)
					quiet = ($urandom_range(0, 3) == 0);
				stall_left = quiet ? 0 : $urandom_range(0, MAX_GAP);
			end else if (stall_left != 0) begin
				stall_left--;
			end
			if (hold_left != 0)
				hold_left--;
			out_stall <= (stall_left != 0) || (hold_left != 0);
		end
	end

	// End the run when nothing moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("size_latency_histogram verification failed");
			$finish;
		end
	end

	// Extremes under the reset limits, clear, read and the unused code.
	task automatic test_reset_state();
		send_request(record_at('0, 32'd0, 10'd0, 32'd0, 10'd0));
		send_request(record_at(SIZE_MAX, 32'd5, 10'd500, 32'd5, 10'd499));
		send_request(record_at(40'd1, 32'd0, 10'd0, TIME_MAX, 10'h3FF));
		send_request(record_at(40'd1, TIME_MAX, 10'h3FF, 32'd0, 10'd0));
		send_request(record_at(40'd2, 32'd0, 10'd0, 32'd4294967, 10'd295));
		send_request(record_at(40'd2, 32'd0, 10'd0, 32'd4294967, 10'd296));
		send_request(simple_req(REQ_READ, 2'd0, 2'd0));
		send_request(simple_req(REQ_UNUSED, 2'd3, 2'd3));
		send_request(simple_req(REQ_CLEAR, 2'd0, 2'd0));
		send_request(simple_req(REQ_READ, 2'd0, 2'd0));
		send_request(simple_req(REQ_READ, 2'd3, 2'd3));
	endtask

	// Inclusive edges of each bin, no size bin, no time bin, overlong milliseconds.
	task automatic test_bin_edges();
		size_set_t sz;
		time_set_t tm;
		sz = '{40'd100, 40'd1000, 40'd1_000_000, SIZE_MAX - 1'b1};
		tm = '{32'd0, 32'd999, 32'd60000, TIME_MAX - 1'b1};
		program_limits(sz, tm);
		send_request(record_at(40'd100, 32'd7, 10'd0, 32'd7, 10'd0));
		send_request(record_at(40'd101, 32'd7, 10'd0, 32'd7, 10'd1));
		send_request(record_at(40'd1000, 32'd7, 10'd0, 32'd7, 10'd999));
		send_request(record_at(40'd1_000_000, 32'd7, 10'd0, 32'd8, 10'd0));
		send_request(record_at(SIZE_MAX - 1'b1, 32'd7, 10'd0, 32'd67, 10'd0));
		send_request(record_at(SIZE_MAX, 32'd7, 10'd0, 32'd7, 10'd0));
		send_request(record_at('0, 32'd0, 10'd0, 32'd4294967, 10'd295));
		send_request(record_at(40'd50, 32'd9, 10'd1023, 32'd9, 10'd0));
		send_request(record_at(40'd50, 32'd9, 10'd0, 32'd9, 10'd1023));
		send_request(record_at(40'd2000, 32'd0, 10'd0, 32'd4294967, 10'd294));
		send_request(simple_req(REQ_READ, 2'd0, 2'd0));
		send_request(simple_req(REQ_READ, 2'd1, 2'd1));
		send_request(simple_req(REQ_READ, 2'd2, 2'd3));
		send_request(simple_req(REQ_READ, 2'd3, 2'd2));
	endtask

	// Random traffic under typical, all-zero, all-ones, unsorted and ascending limits.
	task automatic test_random_phases();
		size_set_t sz;
		time_set_t tm;
		int        p;
		int        n;
		int        i;
		for (p = 0; p < 5; p++) begin
			case (p)
				0: begin
					sz = '{40'd1500, 40'd65536, 40'd10_000_000, 40'd10_000_000_000};
					tm = '{32'd10, 32'd1000, 32'd60000, 32'd3_600_000};
				end
				1: begin
					sz = '{default: '0};
					tm = '{default: '0};
				end
				2: begin
					sz = '{default: SIZE_MAX};
					tm = '{default: TIME_MAX};
				end
				3: begin
					for (i = 0; i < MAX_BINS; i++) begin
						sz[i] = random_bytes() >> $urandom_range(0, SIZE_W-1);
						tm[i] = $urandom >> $urandom_range(0, TIME_W-1);
					end
				end
				default: begin
					sz[0] = random_bytes() >> 12;
					tm[0] = $urandom >> 8;
					for (i = 1; i < MAX_BINS; i++) begin
						sz[i] = sz[i-1] + (random_bytes() >> 3);
						tm[i] = tm[i-1] + ($urandom >> 3);
					end
					sz[MAX_BINS-1] = SIZE_MAX;
					tm[MAX_BINS-1] = TIME_MAX;
				end
			endcase
			program_limits(sz, tm);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 40 == 0)
					sender_quiet = ($urandom_range(0, 3) == 0);
				send_request(random_request());
			end
		end
		sender_quiet = 1'b0;
	endtask

	// Hold the output long enough that the block backs up and stalls its input.
	task automatic test_output_backpressure();
		sender_quiet  = 1'b1;
		long_hold_req = LONG_HOLD;
		repeat (120) send_request(random_request());
		sender_quiet = 1'b0;
	endtask

	// Pause the sender until every result is back, then resume.
	task automatic test_drain_pause();
		repeat (60) send_request(random_request());
		wait_idle();
		repeat (60) send_request(random_request());
	endtask

	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		size_lim = '{default: SIZE_MAX};
		time_lim = '{default: TIME_MAX};
		foreach (grid_count[i])
			grid_count[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_bin_edges();
		test_random_phases();
		test_output_backpressure();
		test_drain_pause();
		wait_idle();

		$display("Run covered %0d requests under %0d limit settings; %0d records hit a bin.",
			sent_count, settings_used + 1, counted_count);
		$display("Bin edges, clears, reads, unused codes, a long output hold and a drain pause ran.");
		if (fail_count == 0)
			$display("size_latency_histogram verification clean");
		else
			$display("size_latency_histogram verification failed");
		$finish;
	end

endmodule
